// ----- hw/rtl/stg_pkg.sv -----
// Shared types and constants of the sine tone generator with fade.
// Holds the register indexes, the microcode word layout and the control program.
// No dependencies.
package stg_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_PHASE_INC = 2'd0,
        CFG_PEAK_AMP  = 2'd1,
        CFG_TONE_LEN  = 2'd2,
        CFG_FADE_LEN  = 2'd3
    } t_cfg_idx;

    // Register reset values
    localparam logic [31:0] RST_PHASE_INC = 32'd39370534;
    localparam logic [14:0] RST_PEAK_AMP  = 15'd24000;
    localparam logic [23:0] RST_TONE_LEN  = 24'd48000;
    localparam logic [15:0] RST_FADE_LEN  = 16'd480;

    // Quotient bits of the envelope division (quotient is below 2^15)
    localparam int DIV_STEPS = 15;

    // Datapath operations, one per control word
    typedef enum logic [2:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_LOOKUP,
        OP_SCALE,
        OP_ENV,
        OP_MUL2,
        OP_DIV,
        OP_EMIT
    } t_op;

    // Jump conditions
    typedef enum logic [2:0] {
        JC_NEVER,
        JC_ALWAYS,
        JC_ACCEPT,
        JC_DONE,
        JC_NO_FADE,
        JC_DIV_MORE,
        JC_OUT_FREE
    } t_jc;

    typedef logic [2:0] t_pc;

    localparam t_pc ST_IDLE   = 3'd0;
    localparam t_pc ST_LOOKUP = 3'd1;
    localparam t_pc ST_SCALE  = 3'd2;
    localparam t_pc ST_ENV    = 3'd3;
    localparam t_pc ST_MUL2   = 3'd4;
    localparam t_pc ST_DIV    = 3'd5;
    localparam t_pc ST_EMIT   = 3'd6;
    localparam t_pc ST_SPARE  = 3'd7;

    // On a taken condition go to target; otherwise hold the step if hold is
    // set, else advance by one.
    typedef struct packed {
        t_op op;
        t_jc cond;
        logic hold;
        t_pc target;
    } t_uword;

    localparam t_uword UCODE [0:7] = '{
        '{OP_ACCEPT, JC_ACCEPT,   1'b1, ST_LOOKUP},
        '{OP_LOOKUP, JC_DONE,     1'b0, ST_EMIT},
        '{OP_SCALE,  JC_NEVER,    1'b0, ST_IDLE},
        '{OP_ENV,    JC_NO_FADE,  1'b0, ST_EMIT},
        '{OP_MUL2,   JC_NEVER,    1'b0, ST_IDLE},
        '{OP_DIV,    JC_DIV_MORE, 1'b0, ST_DIV},
        '{OP_EMIT,   JC_OUT_FREE, 1'b1, ST_IDLE},
        '{OP_NOP,    JC_ALWAYS,   1'b0, ST_IDLE}
    };

endpackage

// ----- hw/rtl/sine_tone_generator_with_fade.sv -----
// Sine tone generator with linear fade-in and fade-out, microcoded control.
// Depends on stg_pkg for register indexes, microcode types and the program.
//
// Each accepted request produces one stereo frame: a quarter-wave sine table
// lookup addressed by a 32-bit phase accumulator, scaled by the peak amplitude
// and by a linear envelope over the first and last fade_length frames. A frame
// inside a fade passes the lookup, scale, envelope, multiply and bit-serial
// divider steps before the final step writes the output register; a frame
// outside the fades skips multiply and divider, and one after the tone has ended
// goes from the lookup straight to the final step. One frame is in work at a
// time; the next request is taken in the idle step that follows the write of
// the result. The final step waits only while the output register is still full.
// The sine table is a constant ROM of QUARTER_TABLE_DEPTH+1 entries with a
// registered read. The restart input clears phase and frame count before the
// frame it comes with.
module sine_tone_generator_with_fade
    import stg_pkg::*;
#(
    parameter int QUARTER_TABLE_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input requests
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_restart,
    // results
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_sample_left,
    output logic signed [15:0] o_sample_right,
    output logic               o_final_frame,
    output logic               o_done_res,
    // configuration writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int IDX_W  = $clog2(QUARTER_TABLE_DEPTH);
    localparam int ADDR_W = $clog2(QUARTER_TABLE_DEPTH + 1);

    // Taylor series of sin(x) in Q2.30 up to x^13/13!, rounded to unsigned Q0.15 (scaled by 32767)
    function automatic logic [14:0] quarter_sine(input longint unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          s;
        x    = (64'd1686629713 * k) / QUARTER_TABLE_DEPTH;
        x2   = (x * x) >> 30;
        s    = longint'(x);
        term = (x * x2) / 6;
        s    = s - longint'(term);
        term = (term * x2) / 20;
        s    = s + longint'(term);
        term = (term * x2) / 42;
        s    = s - longint'(term);
        term = (term * x2) / 72;
        s    = s + longint'(term);
        term = (term * x2) / 110;
        s    = s - longint'(term);
        term = (term * x2) / 156;
        s    = s + longint'(term);
        if (s < 0) begin
            s = 0;
        end
        if (s > 64'sd1073741824) begin
            s = 64'sd1073741824;
        end
        return 15'((($unsigned(s) * 64'd32767) + 64'd536870912) >> 30);
    endfunction

    logic [14:0] w_sine_rom [0:QUARTER_TABLE_DEPTH];

    for (genvar k = 0; k <= QUARTER_TABLE_DEPTH; k++) begin : g_rom
        assign w_sine_rom[k] = quarter_sine(64'(k));
    end

    // configuration
    logic [31:0] r_phase_inc;
    logic [14:0] r_peak;
    logic [23:0] r_tone;
    logic [15:0] r_fade;

    // state
    logic [31:0] r_phase;
    logic [23:0] r_frame;

    // sequencer
    t_pc    r_pc;
    t_pc    n_pc;
    t_uword w_uw;
    logic   w_take;

    // datapath
    logic [14:0] r_tab;
    logic        r_neg;
    logic        r_done;
    logic [29:0] r_prod;
    logic [15:0] r_num;
    logic [15:0] r_rem;
    logic [14:0] r_mag;
    logic [3:0]  r_cnt;

    // result register
    logic               r_out_valid;
    logic signed [15:0] r_sample;
    logic               r_final;
    logic               r_done_out;

    logic                    w_in_acc;
    logic                    w_out_free;
    logic                    w_cfg_we;
    logic [30+ADDR_W-1:0]    w_idx_prod;
    logic [IDX_W-1:0]        w_idx;
    logic [ADDR_W-1:0]       w_addr;
    logic                    w_done;
    logic                    w_fade_in;
    logic                    w_fade_out;
    logic [23:0]             w_tail;
    logic [15:0]             w_num;
    logic [45:0]             w_mul2;
    logic [17:0]             w_trial;
    logic [15:0]             w_mag16;
    logic [15:0]             w_sample;

    assign o_stall     = (r_pc != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_valid && !o_stall;
    assign w_out_free  = !r_out_valid || !i_stall;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    // table index from the low 30 phase bits; mirror on odd quadrants
    assign w_idx_prod = r_phase[29:0] * ADDR_W'(QUARTER_TABLE_DEPTH);
    assign w_idx      = w_idx_prod[30 +: IDX_W];
    assign w_addr     = r_phase[30] ? ADDR_W'(QUARTER_TABLE_DEPTH) - ADDR_W'(w_idx)
                                    : ADDR_W'(w_idx);

    assign w_done     = (r_frame >= r_tone);
    assign w_fade_in  = (r_fade != 16'd0) && (r_frame < 24'(r_fade));
    assign w_fade_out = (r_fade != 16'd0) &&
                        (({1'b0, r_frame} + 25'(r_fade)) >= {1'b0, r_tone});
    assign w_tail     = r_tone - r_frame - 24'd1;
    assign w_num      = w_fade_in ? r_frame[15:0] : w_tail[15:0];

    assign w_mul2  = r_prod * r_num;
    assign w_trial = {1'b0, r_rem, r_mag[14]} - {2'b00, r_fade};

    assign w_mag16  = {1'b0, r_mag};
    assign w_sample = r_done ? 16'd0 : (r_neg ? 16'd0 - w_mag16 : w_mag16);

    // step counter
    assign w_uw = UCODE[r_pc];

    always_comb begin
        unique case (w_uw.cond)
            JC_NEVER:    w_take = 1'b0;
            JC_ALWAYS:   w_take = 1'b1;
            JC_ACCEPT:   w_take = w_in_acc;
            JC_DONE:     w_take = w_done;
            JC_NO_FADE:  w_take = !(w_fade_in || w_fade_out);
            JC_DIV_MORE: w_take = (r_cnt != 4'd0);
            JC_OUT_FREE: w_take = w_out_free;
            default:     w_take = 1'b0;
        endcase
        priority if (w_take) begin
            n_pc = w_uw.target;
        end else if (w_uw.hold) begin
            n_pc = r_pc;
        end else begin
            n_pc = r_pc + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_phase_inc <= RST_PHASE_INC;
            r_peak      <= RST_PEAK_AMP;
            r_tone      <= RST_TONE_LEN;
            r_fade      <= RST_FADE_LEN;
            r_phase     <= 32'd0;
            r_frame     <= 24'd0;
        end else begin
            r_pc <= n_pc;

            if (w_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_PHASE_INC: r_phase_inc <= i_cfg_data;
                    CFG_PEAK_AMP:  r_peak      <= i_cfg_data[14:0];
                    CFG_TONE_LEN:  r_tone      <= i_cfg_data[23:0];
                    CFG_FADE_LEN:  r_fade      <= i_cfg_data[15:0];
                    default: ;
                endcase
            end

            // drop the result once taken, unless the final step refills it below
            if (r_out_valid && !i_stall && (w_uw.op != OP_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (w_uw.op)
                OP_NOP: ;
                OP_ACCEPT: begin
                    if (w_in_acc && i_restart) begin
                        r_phase <= 32'd0;
                        r_frame <= 24'd0;
                    end
                end
                OP_LOOKUP: begin
                    r_tab  <= w_sine_rom[w_addr];
                    r_neg  <= r_phase[31];
                    r_done <= w_done;
                end
                OP_SCALE: begin
                    r_prod <= r_tab * r_peak;
                end
                OP_ENV: begin
                    r_num <= w_num;
                    r_mag <= r_prod[29:15];
                end
                OP_MUL2: begin
                    // dividend is (prod*num) >> 15; its top half is below fade_length
                    {r_rem, r_mag} <= w_mul2[45:15];
                    r_cnt          <= 4'(DIV_STEPS - 1);
                end
                OP_DIV: begin
                    // restoring division: shift dividend bits out, quotient bits in
                    if (w_trial[17]) begin
                        r_rem <= {r_rem[14:0], r_mag[14]};
                    end else begin
                        r_rem <= w_trial[15:0];
                    end
                    r_mag <= {r_mag[13:0], !w_trial[17]};
                    r_cnt <= r_cnt - 4'd1;
                end
                OP_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_sample    <= $signed(w_sample);
                        r_final     <= !r_done && (r_frame == r_tone - 24'd1);
                        r_done_out  <= r_done;
                        if (!r_done) begin
                            r_phase <= r_phase + r_phase_inc;
                            r_frame <= r_frame + 24'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_sample_left  = r_sample;
    assign o_sample_right = r_sample;
    assign o_final_frame  = r_final;
    assign o_done_res     = r_done_out;

    // an accepted request starts the table lookup next cycle
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_pc == ST_LOOKUP))
        else $error("accepted request did not start lookup");

    // a silent frame carries no sample and no final flag
    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_done_res) |-> ((o_sample_left == 16'sd0) && !o_final_frame))
        else $error("done frame carries a sample");

    // partial remainder stays below the divisor throughout the division
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == ST_DIV) |-> (r_rem < r_fade))
        else $error("divider remainder out of range");

    // a new result appears only out of the final step
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid ##1 r_out_valid) |-> ($past(r_pc) == ST_EMIT))
        else $error("result written outside the final step");

    // both channels always match
    a_stereo_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sample_left == o_sample_right))
        else $error("channels differ");

endmodule
